// File: sv/cfr_pkg.sv
// Shared types and constants for the command frame CRC-16 transmitter.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [7:0]  ACK_BYTE       = 8'hFF;
    localparam logic [7:0]  DEV_ADDR_RESET = 8'd128;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_ACK   = 2'd1;
    localparam logic [1:0] ST_NAK   = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       end_of_run;
    } t_out_word;

    typedef enum logic [2:0] {
        JOB_START,
        JOB_BODY,
        JOB_ACK,
        JOB_NAK,
        JOB_ORDER
    } t_job_op;

    typedef struct packed {
        t_job_op    op;
        logic [7:0] value;
        logic       last;
    } t_job;

    typedef enum logic [1:0] {
        STEP_FIRST,
        STEP_CMD,
        STEP_CRC_HI,
        STEP_CRC_LO
    } t_step;

endpackage

`default_nettype wire

// File: sv/command_frame_crc16_tx.sv
// Top level of the command frame transmitter with CRC-16 and reply check.
`timescale 1ns / 1ps
`default_nettype none

// Builds command frames: a start word emits the device address and command byte,
// each payload word its byte, and the word marked last is followed by the CRC-16
// (poly 0x1021, init 0, MSB first) high then low byte; a reply word reports
// acknowledge (0xFF), failure, or out-of-order. The front end takes one input word
// per cycle while the job queue (QUEUE_DEPTH entries) has room. The sequencer puts
// out one output word per cycle while the receiver does not stall, through its single
// output register; an item causes from one to four result words.
module command_frame_crc16_tx
    import cfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    input  wire t_in_word   i_in_word,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output t_out_word       o_out_word,
    input  wire logic       i_out_stall
);

    logic [7:0] r_device_address;
    logic       full;
    logic       empty;
    logic       push;
    logic       pop;
    t_job       push_job;
    t_job       head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEV_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_device_address <= i_cfg_data;
        end
    end

    cfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    cfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_empty    (empty)
    );

    cfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_device_address (r_device_address),
        .i_job            (head_job),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .o_out_word       (o_out_word),
        .i_out_stall      (i_out_stall)
    );

endmodule

`default_nettype wire

// File: sv/cfr_front.sv
// Front end: accepts input words, tracks frame order and queues jobs.
`timescale 1ns / 1ps
`default_nettype none

module cfr_front
    import cfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_word i_in_word,
    output logic          o_in_stall,
    input  wire logic     i_full,
    output logic          o_push,
    output t_job          o_job
);

    logic r_frame_open;
    logic r_awaiting_reply;
    logic n_frame_open;
    logic n_awaiting_reply;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        n_frame_open     = r_frame_open;
        n_awaiting_reply = r_awaiting_reply;
        o_job.op         = JOB_ORDER;
        o_job.value      = i_in_word.value;
        o_job.last       = i_in_word.last;
        case (i_in_word.kind)
            KIND_START: begin
                o_job.op         = JOB_START;
                n_frame_open     = !i_in_word.last;
                n_awaiting_reply = i_in_word.last;
            end
            KIND_PAYLOAD: begin
                if (r_frame_open) begin
                    o_job.op = JOB_BODY;
                    if (i_in_word.last) begin
                        n_frame_open     = 1'b0;
                        n_awaiting_reply = 1'b1;
                    end
                end
            end
            KIND_REPLY: begin
                if (r_awaiting_reply) begin
                    o_job.op         = (i_in_word.value == ACK_BYTE) ? JOB_ACK : JOB_NAK;
                    n_awaiting_reply = 1'b0;
                end
            end
            default: begin
                o_job.op = JOB_ORDER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open     <= 1'b0;
            r_awaiting_reply <= 1'b0;
        end else if (o_push) begin
            r_frame_open     <= n_frame_open;
            r_awaiting_reply <= n_awaiting_reply;
        end
    end

endmodule

`default_nettype wire

// File: sv/cfr_queue.sv
// Small job queue between the front end and the frame sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cfr_queue
    import cfr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: sv/cfr_back.sv
// Frame sequencer: turns queued jobs into output words and keeps the CRC.
`timescale 1ns / 1ps
`default_nettype none

module cfr_back
    import cfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_device_address,
    input  wire t_job       i_job,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    output t_out_word       o_out_word,
    input  wire logic       i_out_stall
);

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    t_step       r_step;
    t_step       n_step;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;
    logic        advance;
    logic        done;
    logic        crc_upd;
    logic [15:0] crc_base;
    logic [7:0]  crc_byte;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_step      = r_step;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        o_pop       = 1'b0;
        done        = 1'b0;
        crc_upd     = 1'b0;
        crc_base    = r_crc;
        crc_byte    = i_job.value;
        if (advance && !i_empty) begin
            n_out_valid         = 1'b1;
            n_out_word.out_byte = 8'h00;
            n_out_word.status   = ST_BYTE;
            case (r_step)
                STEP_CRC_HI: begin
                    n_out_word.out_byte = r_crc[15:8];
                    n_step              = STEP_CRC_LO;
                end
                STEP_CRC_LO: begin
                    n_out_word.out_byte = r_crc[7:0];
                    done                = 1'b1;
                end
                STEP_CMD: begin
                    n_out_word.out_byte = i_job.value;
                    crc_upd             = 1'b1;
                    if (i_job.last) begin
                        n_step = STEP_CRC_HI;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: begin
                    case (i_job.op)
                        JOB_START: begin
                            // address opens the frame, CRC restarts from zero
                            n_out_word.out_byte = i_device_address;
                            crc_base            = '0;
                            crc_byte            = i_device_address;
                            crc_upd             = 1'b1;
                            n_step              = STEP_CMD;
                        end
                        JOB_BODY: begin
                            n_out_word.out_byte = i_job.value;
                            crc_upd             = 1'b1;
                            if (i_job.last) begin
                                n_step = STEP_CRC_HI;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        JOB_ACK: begin
                            n_out_word.status = ST_ACK;
                            done              = 1'b1;
                        end
                        JOB_NAK: begin
                            n_out_word.status = ST_NAK;
                            done              = 1'b1;
                        end
                        default: begin
                            n_out_word.status = ST_ORDER;
                            done              = 1'b1;
                        end
                    endcase
                end
            endcase
            n_out_word.end_of_run = done;
            if (crc_upd) begin
                n_crc = crc_feed(crc_base, crc_byte);
            end
            if (done) begin
                o_pop  = 1'b1;
                n_step = STEP_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_FIRST;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status != ST_BYTE) |-> r_out_word.end_of_run)
        else $error("status word not marked end of run");

    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status != ST_BYTE) |-> (r_out_word.out_byte == 8'h00))
        else $error("status word carries a byte");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_FIRST) |-> !i_empty)
        else $error("sequencer mid-job with empty queue");

endmodule

`default_nettype wire

// File: test/tb_command_frame_crc16_tx.sv
// Testbench for command_frame_crc16_tx: directed table, then random frames checked by a predictor.
`timescale 1ns / 1ps

module tb_command_frame_crc16_tx;
    import cfr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic       ROW_TYPED   = 1'b1;
    localparam logic       ROW_MODEL   = 1'b0;
    localparam int         PHASE_WORDS = 110;
    localparam int         IDLE_PAUSE  = 8;
    localparam int         CYCLE_LIMIT = 400_000;

    typedef struct packed {
        t_in_word   w;
        logic       use_typed;
        logic [1:0] typed_st;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    command_frame_crc16_tx DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    // predictor state
    logic [7:0]  dev_addr = DEV_ADDR_RESET;
    logic [15:0] frame_crc = 16'h0000;
    logic        frame_open = 1'b0;
    logic        reply_pending = 1'b0;

    t_out_word expected_words[$];
    t_out_word step_words[$];
    t_dir_row  dir_table[$];
    t_out_word want;

    int fail_count = 0;
    int items_sent = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int addr_settings = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void frame_add_byte(input logic [7:0] b);
        frame_crc = crc16_feed(frame_crc, b);
        step_words.push_back(t_out_word'({b, ST_BYTE, 1'b0}));
    endfunction

    function automatic void frame_close();
        step_words.push_back(t_out_word'({frame_crc[15:8], ST_BYTE, 1'b0}));
        step_words.push_back(t_out_word'({frame_crc[7:0], ST_BYTE, 1'b0}));
        frame_open = 1'b0;
        reply_pending = 1'b1;
    endfunction

    // Advances the frame state for one accepted word; records its results when keep is set.
    function automatic void predict_frame_word(input t_in_word w, input bit keep);
        t_out_word r;
        step_words.delete();
        case (w.kind)
            KIND_START: begin
                frame_crc = 16'h0000;
                reply_pending = 1'b0;
                frame_open = 1'b1;
                frame_add_byte(dev_addr);
                frame_add_byte(w.value);
                if (w.last)
                    frame_close();
            end
            KIND_PAYLOAD: begin
                if (frame_open) begin
                    frame_add_byte(w.value);
                    if (w.last)
                        frame_close();
                end else begin
                    step_words.push_back(t_out_word'({8'h00, ST_ORDER, 1'b0}));
                end
            end
            KIND_REPLY: begin
                if (reply_pending) begin
                    reply_pending = 1'b0;
                    step_words.push_back(t_out_word'({8'h00,
                        (w.value == ACK_BYTE) ? ST_ACK : ST_NAK, 1'b0}));
                end else begin
                    step_words.push_back(t_out_word'({8'h00, ST_ORDER, 1'b0}));
                end
            end
            default: begin
                step_words.push_back(t_out_word'({8'h00, ST_ORDER, 1'b0}));
            end
        endcase
        if (keep) begin
            for (int i = 0; i < step_words.size(); i++) begin
                r = step_words[i];
                r.end_of_run = (i == step_words.size() - 1);
                expected_words.push_back(r);
            end
        end
    endfunction

    // Sender works in bursts; the word stays on the bus until accepted.
    task automatic send_word(input t_in_word w, input logic use_typed, input logic [1:0] typed_st);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (use_typed) begin
            predict_frame_word(w, 1'b0);
            expected_words.push_back(t_out_word'({8'h00, typed_st, 1'b1}));
        end else begin
            predict_frame_word(w, 1'b1);
        end
        items_sent++;
        burst_left--;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dev_addr = a;
        addr_settings++;
    endtask

    // Well-formed frame with random content; now and then truncated so the next start abandons it.
    task automatic send_frame();
        t_in_word w;
        int n_pay;
        int n_sent;
        bit truncate;
        n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        truncate = (n_pay > 0) && ($urandom_range(0, 9) == 0);
        n_sent = truncate ? n_pay - 1 : n_pay;
        w.kind  = KIND_START;
        w.value = 8'($urandom_range(0, 255));
        w.last  = (n_pay == 0);
        send_word(w, ROW_MODEL, ST_BYTE);
        frames_sent++;
        for (int i = 0; i < n_sent; i++) begin
            w.kind  = KIND_PAYLOAD;
            w.value = 8'($urandom_range(0, 255));
            w.last  = (i == n_pay - 1);
            send_word(w, ROW_MODEL, ST_BYTE);
        end
        if (!truncate && $urandom_range(0, 9) != 0) begin
            w.kind  = KIND_REPLY;
            w.value = $urandom_range(0, 1) ? ACK_BYTE : 8'($urandom_range(0, 255));
            w.last  = 1'($urandom_range(0, 1));
            send_word(w, ROW_MODEL, ST_BYTE);
        end
    endtask

    // Receiver stall pattern: free-running, random, or mostly stalled, in runs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(4, 40);
                stall_mode = $urandom_range(0, 2);
            end
            stall_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_byte %h status %0d end_of_run %0d",
                       o_out_word.out_byte, o_out_word.status, o_out_word.end_of_run);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                results_checked++;
                if (o_out_word.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, o_out_word.out_byte);
                    fail_count++;
                end
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_word.status);
                    fail_count++;
                end
                if (o_out_word.end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0d, got %0d",
                           want.end_of_run, o_out_word.end_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_in_word w;
        int phase_start;
        logic [7:0] next_addr;

        // kind, value, last, typed?, typed status
        dir_table = '{
            {KIND_REPLY,   8'hFF, 1'b0, ROW_TYPED, ST_ORDER},  // nothing pending
            {KIND_PAYLOAD, 8'h12, 1'b0, ROW_TYPED, ST_ORDER},  // no open frame
            {KIND_UNUSED,  8'hAA, 1'b1, ROW_TYPED, ST_ORDER},
            {KIND_START,   8'h00, 1'b1, ROW_MODEL, ST_BYTE},   // empty body, reset address
            {KIND_REPLY,   8'hFF, 1'b0, ROW_TYPED, ST_ACK},
            {KIND_START,   8'hFF, 1'b0, ROW_MODEL, ST_BYTE},
            {KIND_PAYLOAD, 8'h00, 1'b0, ROW_MODEL, ST_BYTE},
            {KIND_PAYLOAD, 8'hFF, 1'b0, ROW_MODEL, ST_BYTE},
            {KIND_PAYLOAD, 8'h5A, 1'b1, ROW_MODEL, ST_BYTE},
            {KIND_REPLY,   8'h00, 1'b1, ROW_TYPED, ST_NAK},
            {KIND_REPLY,   8'hFF, 1'b0, ROW_TYPED, ST_ORDER},  // reply already taken
            {KIND_START,   8'h21, 1'b0, ROW_MODEL, ST_BYTE},
            {KIND_PAYLOAD, 8'h01, 1'b0, ROW_MODEL, ST_BYTE},
            {KIND_START,   8'h37, 1'b0, ROW_MODEL, ST_BYTE},   // abandons open frame
            {KIND_PAYLOAD, 8'h80, 1'b1, ROW_MODEL, ST_BYTE},
            {KIND_START,   8'h42, 1'b1, ROW_MODEL, ST_BYTE},   // abandons pending reply
            {KIND_START,   8'h10, 1'b1, ROW_MODEL, ST_BYTE},
            {KIND_REPLY,   8'hFE, 1'b0, ROW_TYPED, ST_NAK},
            {KIND_PAYLOAD, 8'h33, 1'b1, ROW_TYPED, ST_ORDER},  // frame already closed
            {KIND_UNUSED,  8'h55, 1'b0, ROW_TYPED, ST_ORDER},
            {KIND_START,   8'hAA, 1'b0, ROW_MODEL, ST_BYTE},
            {KIND_PAYLOAD, 8'h55, 1'b1, ROW_MODEL, ST_BYTE},
            {KIND_REPLY,   8'hFF, 1'b1, ROW_TYPED, ST_ACK}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r])
            send_word(dir_table[r].w, dir_table[r].use_typed, dir_table[r].typed_st);

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: next_addr = 8'h00;
                1: next_addr = 8'hFF;
                default: next_addr = 8'($urandom_range(0, 255));
            endcase
            write_address(next_addr);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_WORDS) begin
                if ($urandom_range(0, 99) < 12) begin
                    w.kind  = 2'($urandom_range(0, 3));
                    w.value = 8'($urandom_range(0, 255));
                    w.last  = 1'($urandom_range(0, 1));
                    send_word(w, ROW_MODEL, ST_BYTE);
                end else begin
                    send_frame();
                end
            end
        end

        wait_idle();
        $display("Sent %0d input words (%0d random frames) under %0d address settings;",
                 items_sent, frames_sent, addr_settings + 1);
        $display("checked %0d result words in %0d cycles.", results_checked, cycle_count);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
sv/cfr_pkg.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/command_frame_crc16_tx.sv
test/tb_command_frame_crc16_tx.sv
